FILE: hw/rtl/linear_color_ramp_generator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear color ramp generator
// Each macro checks one implication on the rising edge of clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_COLOR_RAMP_GENERATOR_UNIT_ASSERT_SVH
`define LINEAR_COLOR_RAMP_GENERATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCRG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LCRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lcrg_pkg.sv
// ----------------------------------------------------------------------------
// lcrg_pkg
// Shared types and constants of the linear color ramp generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcrg_pkg;

  localparam int CHAN_W     = 8;                // color channel width
  localparam int CNT_W      = 7;                // point count width
  localparam int IDX_W      = 6;                // point index width
  localparam int DIV_CNT_W  = $clog2(CHAN_W);   // one quotient bit per step

  typedef struct packed {
    logic [CHAN_W-1:0] start_red;
    logic [CHAN_W-1:0] start_green;
    logic [CHAN_W-1:0] start_blue;
    logic [CHAN_W-1:0] end_red;
    logic [CHAN_W-1:0] end_green;
    logic [CHAN_W-1:0] end_blue;
    logic [CNT_W-1:0]  point_count;
  } req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [IDX_W-1:0]  point_index;
    logic              last_point;
  } pt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch request, start the per-channel division
    logic div_step;   // one restoring division step
    logic emit;       // load the output register and advance the ramp
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_empty;  // request carries a zero point count
    logic div_last;   // final division step this cycle
    logic last;       // current point is the final one
    logic out_free;   // output register can take a point this cycle
  } status_t;

endpackage

FILE: hw/rtl/lcrg_chan.sv
// ----------------------------------------------------------------------------
// lcrg_chan
// One color channel: serial division of |end-start| by N-1, then an
// incremental quotient/remainder walk that yields one rounded point per emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcrg_chan
  import lcrg_pkg::*;
(
  input  logic              clk,
  input  logic              capture,
  input  logic              div_step,
  input  logic              emit,
  input  logic [CHAN_W-1:0] s_in,
  input  logic [CHAN_W-1:0] e_in,
  input  logic [IDX_W-1:0]  den,
  output logic [CHAN_W-1:0] value
);

  logic [CHAN_W-1:0] s;
  logic              neg;
  logic [CHAN_W-1:0] dq;    // dividend bits in, quotient bits out
  logic [IDX_W-1:0]  rem;
  logic [CHAN_W-1:0] q;     // rounded offset of the current point
  logic [CHAN_W-1:0] r;     // running remainder, biased by den for rounding

  logic [IDX_W:0]    rem_sh;
  logic              fits;
  logic [IDX_W:0]    rem_new;
  logic [CHAN_W-1:0] sum;
  logic [CHAN_W-1:0] two_den;
  logic              wrap;

  always_comb begin
    rem_sh  = {rem, dq[CHAN_W-1]};
    fits    = rem_sh >= {1'b0, den};
    rem_new = fits ? rem_sh - {1'b0, den} : rem_sh;
    // 2*diff = quotient*2den + 2*remainder; add the latter each point
    sum     = r + CHAN_W'({rem, 1'b0});
    two_den = CHAN_W'({den, 1'b0});
    wrap    = sum >= two_den;
    value   = neg ? s - q : s + q;
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      s   <= s_in;
      neg <= e_in < s_in;
      dq  <= (e_in < s_in) ? s_in - e_in : e_in - s_in;
      rem <= '0;
    end else if (div_step) begin
      rem <= rem_new[IDX_W-1:0];
      dq  <= {dq[CHAN_W-2:0], fits};
      // point zero: numerator equals den, offset zero
      q   <= '0;
      r   <= CHAN_W'(den);
    end else if (emit) begin
      r <= wrap ? sum - two_den : sum;
      q <= q + dq + CHAN_W'(wrap);
    end
  end

endmodule

FILE: hw/rtl/lcrg_datapath.sv
// ----------------------------------------------------------------------------
// lcrg_datapath
// Request capture, division step counter, point index and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcrg_datapath
  import lcrg_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  req_t    req,
  input  cmd_t    cmd,
  output status_t status,
  output logic    pt_valid,
  input  logic    pt_ready,
  output pt_t     pt
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  logic [IDX_W-1:0]     den;
  logic [IDX_W-1:0]     idx;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [CNT_W-1:0]     cnt_sat;
  logic [CHAN_W-1:0]    red_val;
  logic [CHAN_W-1:0]    green_val;
  logic [CHAN_W-1:0]    blue_val;

  always_comb begin
    cnt_sat          = (req.point_count > MAX_CNT) ? MAX_CNT : req.point_count;
    status.req_empty = req.point_count == '0;
    status.div_last  = div_cnt == DIV_CNT_W'(CHAN_W - 1);
    status.last      = idx == den;
    status.out_free  = !pt_valid || pt_ready;
  end

  lcrg_chan u_red (
    .clk(clk), .capture(cmd.capture), .div_step(cmd.div_step), .emit(cmd.emit),
    .s_in(req.start_red), .e_in(req.end_red), .den(den), .value(red_val)
  );

  lcrg_chan u_green (
    .clk(clk), .capture(cmd.capture), .div_step(cmd.div_step), .emit(cmd.emit),
    .s_in(req.start_green), .e_in(req.end_green), .den(den), .value(green_val)
  );

  lcrg_chan u_blue (
    .clk(clk), .capture(cmd.capture), .div_step(cmd.div_step), .emit(cmd.emit),
    .s_in(req.start_blue), .e_in(req.end_blue), .den(den), .value(blue_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt  <= '0;
      idx      <= '0;
      den      <= '0;
      pt_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        den     <= IDX_W'(cnt_sat - CNT_W'(1));
        div_cnt <= '0;
        idx     <= '0;
      end else begin
        if (cmd.div_step) begin
          div_cnt <= div_cnt + DIV_CNT_W'(1);
        end
        if (cmd.emit) begin
          idx <= idx + IDX_W'(1);
        end
      end
      if (cmd.emit) begin
        pt_valid <= 1'b1;
      end else if (pt_ready) begin
        pt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pt.red_out     <= red_val;
      pt.green_out   <= green_val;
      pt.blue_out    <= blue_val;
      pt.point_index <= idx;
      pt.last_point  <= idx == den;
    end
  end

endmodule

FILE: hw/rtl/lcrg_ctrl.sv
// ----------------------------------------------------------------------------
// lcrg_ctrl
// Sequencer: accept a request, run the division steps, then emit the points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcrg_ctrl
  import lcrg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        // drop a request with a zero point count
        if (req_valid && !status.req_empty) begin
          cmd.capture = 1'b1;
          state_next  = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/linear_color_ramp_generator_unit.sv
// ----------------------------------------------------------------------------
// linear_color_ramp_generator_unit
// After a request is taken, 8 serial division steps run, then the first point
// of the ramp is loaded into the output register.
// Throughput: one point per cycle while pt_ready stays high; the restoring
// divider runs once per request, before its first point.
// Reset (rst, synchronous): sequencer idle, output register empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_color_ramp_generator_unit_assert.svh"

module linear_color_ramp_generator_unit
  import lcrg_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic pt_valid,
  input  logic pt_ready,
  output pt_t  pt
);

  // Command and status between sequencer and datapath. The sequencer only
  // takes a request when idle; a point may still wait in the output register
  // then, so the next request's division overlaps the drain of the last point.
  cmd_t    cmd;
  status_t status;

  // Sequencer: idle -> divide (8 steps) -> emit (one point per free slot).
  lcrg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: three channel units share the divisor N-1 and the step count.
  // Each channel divides |end-start| by N-1 once, then walks the ramp by
  // adding quotient and remainder per point, with the remainder biased by
  // N-1 so the offset rounds to nearest, ties away from zero.
  lcrg_datapath #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .cmd     (cmd),
    .status  (status),
    .pt_valid(pt_valid),
    .pt_ready(pt_ready),
    .pt      (pt)
  );

  // A waiting point that is not the final one means the ramp is unfinished.
  `LCRG_ASSERT_NOW(a_busy_mid_ramp, pt_valid && !pt.last_point, !req_ready, "request taken mid ramp")
  // Loading the final point returns the sequencer to idle.
  `LCRG_ASSERT_NEXT(a_idle_after_last, cmd.emit && status.last, req_ready, "not idle after last point")
  // Points are only loaded outside idle.
  `LCRG_ASSERT_NOW(a_emit_not_idle, cmd.emit, !req_ready && !cmd.capture, "emit while idle")

endmodule
